// ===== rtl/core/bzhs_pkg.sv =====
// Shared types and constants for the bounded zoom history stack.
`timescale 1ns / 1ps

package bzhs_pkg;

    localparam int LIMIT_W = 6;
    localparam int AXIS_W  = 2;
    localparam int MOVE_W  = 8;
    localparam int REQ_W   = 2;

    typedef enum logic [REQ_W-1:0] {
        OP_SET_BASE = 2'd0,
        OP_ADD      = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_MOVE     = 2'd3
    } t_op;

    // Axis codes reported while the stack is empty.
    localparam logic [AXIS_W-1:0] EMPTY_X = 2'd0;
    localparam logic [AXIS_W-1:0] EMPTY_Y = 2'd2;

    typedef struct packed {
        logic latch_req;
        logic plan;
        logic copy_rd;
        logic copy_wr;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_compact;
        logic copy_last;
    } t_status;

endpackage

// ===== rtl/core/bzhs_datapath.sv =====
// Datapath of the history stack: entry memory, cursor and fill registers, output word.
`timescale 1ns / 1ps

module bzhs_datapath #(
    parameter int DEPTH       = 32,
    parameter int REGION_BITS = 32,
    localparam int CUR_W      = $clog2(DEPTH),
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bzhs_pkg::t_cmd                 i_cmd,
    output bzhs_pkg::t_status              o_status,
    input  logic                           i_cfg_we,
    input  logic [bzhs_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic [bzhs_pkg::REQ_W-1:0]     i_req_type,
    input  logic [REGION_BITS-1:0]         i_region_data,
    input  logic [bzhs_pkg::AXIS_W-1:0]    i_x_axis,
    input  logic [bzhs_pkg::AXIS_W-1:0]    i_y_axis,
    input  logic                           i_keep_base,
    input  logic signed [bzhs_pkg::MOVE_W-1:0] i_move_delta,
    output logic [REGION_BITS-1:0]         o_cur_region,
    output logic [bzhs_pkg::AXIS_W-1:0]    o_cur_x_axis,
    output logic [bzhs_pkg::AXIS_W-1:0]    o_cur_y_axis,
    output logic                           o_stack_valid,
    output logic [CUR_W-1:0]               o_cursor_pos,
    output logic [CNT_W-1:0]               o_fill_count
);

    localparam int AW    = bzhs_pkg::AXIS_W;
    localparam int ENT_W = REGION_BITS + 2 * AW;
    localparam int CMP_W = (CNT_W > bzhs_pkg::LIMIT_W) ? CNT_W : bzhs_pkg::LIMIT_W;
    localparam int TW    = ((CUR_W > bzhs_pkg::MOVE_W) ? CUR_W : bzhs_pkg::MOVE_W) + 2;

    // Control registers.
    logic [bzhs_pkg::LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]             r_count;
    logic [CUR_W-1:0]             r_cursor;

    // Latched request.
    bzhs_pkg::t_op                r_req_op;
    logic [REGION_BITS-1:0]       r_req_region;
    logic [AW-1:0]                r_req_x;
    logic [AW-1:0]                r_req_y;
    logic                         r_req_keep;
    logic signed [bzhs_pkg::MOVE_W-1:0] r_req_delta;

    // Compaction copy pointers.
    logic [CUR_W-1:0]             r_diff;
    logic [CUR_W-1:0]             r_src;
    logic [CUR_W-1:0]             r_dst;

    // Entry memory and its read side.
    logic [ENT_W-1:0]             r_mem [DEPTH];
    logic [ENT_W-1:0]             r_rd_data;
    logic                         r_byp;
    logic [ENT_W-1:0]             r_byp_data;

    // Output word.
    logic [REGION_BITS-1:0]       r_out_region;
    logic [AW-1:0]                r_out_x;
    logic [AW-1:0]                r_out_y;
    logic                         r_out_valid_flag;
    logic [CUR_W-1:0]             r_out_cursor;
    logic [CNT_W-1:0]             r_out_count;

    logic [CMP_W-1:0]             limit_ext;
    logic [CNT_W-1:0]             eff_limit;
    logic [CNT_W-1:0]             diff_full;
    logic                         keep_cur;
    logic [CUR_W-1:0]             plan_cursor;
    logic [CUR_W-1:0]             plan_src;

    logic signed [TW-1:0]         t_base;
    logic signed [TW-1:0]         t_step;
    logic signed [TW-1:0]         t_sum;
    logic signed [TW-1:0]         t_count;
    logic [CUR_W-1:0]             move_target;
    logic                         add_room;

    logic [CNT_W-1:0]             x_count;
    logic [CUR_W-1:0]             x_cursor;
    logic                         x_we;

    logic [ENT_W-1:0]             req_entry;
    logic                         mem_we;
    logic [CUR_W-1:0]             mem_waddr;
    logic [CUR_W-1:0]             mem_raddr;
    logic [ENT_W-1:0]             mem_wdata;
    logic [ENT_W-1:0]             cur_entry;

    // A limit of 0 or 1, or any value above the capacity, means the full capacity.
    assign limit_ext = CMP_W'(r_limit);
    assign eff_limit = (limit_ext <= CMP_W'(1) || limit_ext > CMP_W'(DEPTH))
                     ? CNT_W'(DEPTH) : CNT_W'(limit_ext);

    assign diff_full   = r_count - eff_limit;
    assign keep_cur    = (r_cursor != '0) && (CNT_W'(r_cursor) <= diff_full);
    assign plan_cursor = keep_cur ? CUR_W'(1)
                       : ((r_cursor != '0) ? (r_cursor - CUR_W'(diff_full)) : '0);
    assign plan_src    = keep_cur ? r_cursor : (CUR_W'(1) + CUR_W'(diff_full));

    assign o_status.need_compact = (r_count > eff_limit);
    assign o_status.copy_last    = (CNT_W'(r_dst) == (eff_limit - CNT_W'(1)));

    // Cursor move: a zero step returns to the base, otherwise clamp to the held entries.
    assign t_base  = TW'(r_cursor);
    assign t_step  = TW'(r_req_delta);
    assign t_count = TW'(r_count);
    assign t_sum   = (r_req_delta == '0) ? '0 : (t_base + t_step);
    assign move_target = t_sum[TW-1] ? '0
                       : ((t_sum >= t_count) ? CUR_W'(r_count - CNT_W'(1)) : CUR_W'(t_sum));

    assign add_room = (({1'b0, CNT_W'(r_cursor)} + (CNT_W + 1)'(2)) <= {1'b0, eff_limit});

    always_comb begin
        x_count  = r_count;
        x_cursor = r_cursor;
        x_we     = 1'b0;
        if (r_req_op == bzhs_pkg::OP_SET_BASE
            || (r_req_op == bzhs_pkg::OP_ADD && r_count == '0)) begin
            x_we     = 1'b1;
            x_count  = CNT_W'(1);
            x_cursor = '0;
        end else begin
            case (r_req_op)
                bzhs_pkg::OP_ADD: begin
                    // At the limit the entry under the cursor is overwritten.
                    x_we = 1'b1;
                    if (add_room) begin
                        x_count  = CNT_W'(r_cursor) + CNT_W'(2);
                        x_cursor = r_cursor + CUR_W'(1);
                    end
                end
                bzhs_pkg::OP_CLEAR: begin
                    if (r_count != '0) begin
                        x_count  = r_req_keep ? CNT_W'(1) : '0;
                        x_cursor = '0;
                    end
                end
                bzhs_pkg::OP_MOVE: begin
                    if (r_count != '0) begin
                        x_cursor = move_target;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign req_entry = {r_req_region, r_req_y, r_req_x};
    assign mem_we    = (i_cmd.exec && x_we) || i_cmd.copy_wr;
    assign mem_waddr = i_cmd.copy_wr ? r_dst : x_cursor;
    assign mem_wdata = i_cmd.copy_wr ? r_rd_data : req_entry;
    assign mem_raddr = i_cmd.copy_rd ? r_src : x_cursor;
    assign cur_entry = r_byp ? r_byp_data : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= '0;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.plan) begin
                r_count  <= eff_limit;
                r_cursor <= plan_cursor;
            end else if (i_cmd.exec) begin
                r_count  <= x_count;
                r_cursor <= x_cursor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req_op     <= bzhs_pkg::t_op'(i_req_type);
            r_req_region <= i_region_data;
            r_req_x      <= i_x_axis;
            r_req_y      <= i_y_axis;
            r_req_keep   <= i_keep_base;
            r_req_delta  <= i_move_delta;
        end
        if (i_cmd.plan) begin
            r_diff <= CUR_W'(diff_full);
            r_src  <= plan_src;
            r_dst  <= CUR_W'(1);
        end else if (i_cmd.copy_wr) begin
            r_dst <= r_dst + CUR_W'(1);
            r_src <= r_dst + CUR_W'(1) + r_diff;
        end
    end

    // Single write port and one registered read port. A write during execution
    // always lands on the new cursor, so the written word is forwarded.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.exec || i_cmd.copy_rd) begin
            r_rd_data <= r_mem[mem_raddr];
        end
        if (i_cmd.exec) begin
            r_byp      <= x_we;
            r_byp_data <= req_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_count != '0) begin
                r_out_region     <= cur_entry[ENT_W-1 -: REGION_BITS];
                r_out_y          <= cur_entry[2*AW-1 -: AW];
                r_out_x          <= cur_entry[AW-1:0];
                r_out_valid_flag <= 1'b1;
            end else begin
                r_out_region     <= '0;
                r_out_y          <= bzhs_pkg::EMPTY_Y;
                r_out_x          <= bzhs_pkg::EMPTY_X;
                r_out_valid_flag <= 1'b0;
            end
            r_out_cursor <= r_cursor;
            r_out_count  <= r_count;
        end
    end

    assign o_cur_region  = r_out_region;
    assign o_cur_x_axis  = r_out_x;
    assign o_cur_y_axis  = r_out_y;
    assign o_stack_valid = r_out_valid_flag;
    assign o_cursor_pos  = r_out_cursor;
    assign o_fill_count  = r_out_count;

    a_plan_sets_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.plan |=> (r_count == $past(eff_limit)))
        else $error("compaction did not set the fill count to the limit");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CNT_W'(r_cursor) < r_count))
        else $error("cursor points past the held entries");

endmodule

// ===== rtl/core/bzhs_ctrl.sv =====
// Controller state machine of the history stack.
`timescale 1ns / 1ps

module bzhs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bzhs_pkg::t_status i_status,
    output bzhs_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CRD  = 5'b00010,
        S_CWR  = 5'b00100,
        S_OP   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_OUT) && out_free);
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.latch_req = accept;
    assign o_cmd.plan      = accept && i_status.need_compact;
    assign o_cmd.copy_rd   = (r_state == S_CRD);
    assign o_cmd.copy_wr   = (r_state == S_CWR);
    assign o_cmd.exec      = (r_state == S_OP);
    assign o_cmd.load_out  = (r_state == S_OUT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_status.need_compact ? S_CRD : S_OP;
                end
            end
            S_CRD: n_state = S_CWR;
            S_CWR: n_state = i_status.copy_last ? S_OP : S_CRD;
            S_OP:  n_state = S_OUT;
            S_OUT: begin
                // The next word may enter in the cycle the result is parked.
                if (accept) begin
                    n_state = i_status.need_compact ? S_CRD : S_OP;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CRD || r_state == S_OP))
        else $error("accepted word did not start processing");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    a_copy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CWR && i_status.copy_last) |=> (r_state == S_OP))
        else $error("compaction did not hand over to execution");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result overwritten while the output stalls");

endmodule

// ===== rtl/core/bounded_zoom_history_stack.sv =====
// Top level of the bounded zoom history stack.
// An accepted word passes the execution state and then the output state, where its
// result is loaded into the output word; the next word is taken while the result is parked.
// After the limit is lowered, the next word first copies L-1 entries down through the
// entry memory, a read state and a write state per entry, L being the effective limit.
// Reset (synchronous, active low) clears fill, cursor, limit and control; entries are not cleared.
`timescale 1ns / 1ps

module bounded_zoom_history_stack #(
    parameter int DEPTH       = 32,
    parameter int REGION_BITS = 32,
    localparam int CUR_W      = $clog2(DEPTH),
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bzhs_pkg::LIMIT_W-1:0]       i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [bzhs_pkg::REQ_W-1:0]         i_req_type,
    input  logic [REGION_BITS-1:0]             i_region_data,
    input  logic [bzhs_pkg::AXIS_W-1:0]        i_x_axis,
    input  logic [bzhs_pkg::AXIS_W-1:0]        i_y_axis,
    input  logic                               i_keep_base,
    input  logic signed [bzhs_pkg::MOVE_W-1:0] i_move_delta,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [REGION_BITS-1:0]             o_cur_region,
    output logic [bzhs_pkg::AXIS_W-1:0]        o_cur_x_axis,
    output logic [bzhs_pkg::AXIS_W-1:0]        o_cur_y_axis,
    output logic                               o_stack_valid,
    output logic [CUR_W-1:0]                   o_cursor_pos,
    output logic [CNT_W-1:0]                   o_fill_count
);

    bzhs_pkg::t_cmd    cmd;
    bzhs_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    bzhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bzhs_datapath #(
        .DEPTH       (DEPTH),
        .REGION_BITS (REGION_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_region_data (i_region_data),
        .i_x_axis      (i_x_axis),
        .i_y_axis      (i_y_axis),
        .i_keep_base   (i_keep_base),
        .i_move_delta  (i_move_delta),
        .o_cur_region  (o_cur_region),
        .o_cur_x_axis  (o_cur_x_axis),
        .o_cur_y_axis  (o_cur_y_axis),
        .o_stack_valid (o_stack_valid),
        .o_cursor_pos  (o_cursor_pos),
        .o_fill_count  (o_fill_count)
    );

endmodule
